// File: src/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/pfcrc_pkg.sv
package pfcrc_pkg;
    localparam int FLOWS     = 256;
    localparam int FLOW_W    = $clog2(FLOWS);
    localparam int RATE_W    = 29;
    localparam int ALPHA_W   = 17;
    localparam int BCNT_W    = 25;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    typedef enum logic [2:0] {
        FN_OPEN  = 3'd0,
        FN_CNP   = 3'd1,
        FN_RTMR  = 3'd2,
        FN_ATMR  = 3'd3,
        FN_SENT  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ACC_NORMAL = 2'd0,
        ACC_FR     = 2'd1,
        ACC_AI     = 2'd2,
        ACC_HYPER  = 2'd3
    } accel_t;

    localparam logic [2:0] REG_INIT_RATE = 3'd0;
    localparam logic [2:0] REG_MAX_RATE  = 3'd1;
    localparam logic [2:0] REG_RATE_AI   = 3'd2;
    localparam logic [2:0] REG_RATE_HAI  = 3'd3;
    localparam logic [2:0] REG_GAMMA     = 3'd4;
    localparam logic [2:0] REG_BYTE_TH   = 3'd5;
    localparam logic [2:0] REG_FR_TH     = 3'd6;

    typedef struct packed {
        logic [RATE_W-1:0]  cur;
        logic [RATE_W-1:0]  tgt;
        logic [ALPHA_W-1:0] alpha;
        logic [BCNT_W-1:0]  bcnt;
        logic [7:0]         bsteps;
        logic [7:0]         tsteps;
        logic [7:0]         hyper;
        logic [1:0]         accel;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [7:0] sat8_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction
endpackage

// File: src/pfcrc_ram.sv
module pfcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/per_flow_congestion_rate_control_top.sv
// Per-flow congestion rate control (reaction point).
// Input stream s_*: one event per transfer; s_tdata = {flow_done, sent_bytes,
// flow_id} from bit 0 up, s_tuser = func. Each event yields exactly one
// result transfer on m_* with the flow's rates, accel state and timer
// restart requests.
// Each event runs a fixed sequence: read the flow entry from the state RAM,
// register the products in the cycle the read data arrives (29x18, 17x17
// and 8x24 multipliers), pass the ST_MUL wait state, then write back and
// load the output register. The next event is taken in the cycle after the
// result transfer, so no new event is taken until the last result is taken.
// Reset clears all flow valid bits (flip-flops) and the registers to their
// defaults at once; the entry RAM needs no clearing pass since only entries
// written by an open are ever used. When m_tready is low the result holds in
// the output register and s_tready stays low until it is taken.
// Registers are written through the APB port at byte address 4*index.
module per_flow_congestion_rate_control_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // flow_id[7:0], sent_bytes[23:8], flow_done[24]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_flow[7:0], found[8], current_rate[37:9],
                                   // target_rate[66:38], accel_state[68:67],
                                   // restart_rate_timer[69], restart_alpha_timer[70]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfcrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_WB   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]  init_rate_reg, max_rate_reg;
    logic [23:0]        rate_ai_reg, rate_hai_reg, byte_th_reg;
    logic [ALPHA_W-1:0] gamma_reg;
    logic [7:0]         fr_th_reg;

    logic [FLOWS-1:0]   valid_reg;

    logic [2:0]         func_reg;
    logic [FLOW_W-1:0]  id_reg;
    logic [15:0]        bytes_reg;
    logic               done_reg;
    logic               inrange_reg;

    logic               m_valid_reg;
    logic [71:0]        m_data_reg;

    // ---------------- configuration ----------------
    logic cfg_we;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_rate_reg <= 29'd100000000;
            max_rate_reg  <= 29'd100000000;
            rate_ai_reg   <= 24'd5000;
            rate_hai_reg  <= 24'd50000;
            gamma_reg     <= 17'd256;
            byte_th_reg   <= 24'd10485760;
            fr_th_reg     <= 8'd5;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_INIT_RATE: init_rate_reg <= pwdata[RATE_W-1:0];
                REG_MAX_RATE:  max_rate_reg  <= pwdata[RATE_W-1:0];
                REG_RATE_AI:   rate_ai_reg   <= pwdata[23:0];
                REG_RATE_HAI:  rate_hai_reg  <= pwdata[23:0];
                REG_GAMMA:     gamma_reg     <= pwdata[ALPHA_W-1:0];
                REG_BYTE_TH:   byte_th_reg   <= pwdata[23:0];
                REG_FR_TH:     fr_th_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INIT_RATE: prdata = {3'd0, init_rate_reg};
            REG_MAX_RATE:  prdata = {3'd0, max_rate_reg};
            REG_RATE_AI:   prdata = {8'd0, rate_ai_reg};
            REG_RATE_HAI:  prdata = {8'd0, rate_hai_reg};
            REG_GAMMA:     prdata = {15'd0, gamma_reg};
            REG_BYTE_TH:   prdata = {8'd0, byte_th_reg};
            REG_FR_TH:     prdata = {24'd0, fr_th_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    logic s_fire, m_fire, out_free;
    assign m_fire   = m_valid_reg & m_tready;
    assign out_free = ~m_valid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE) & ~m_valid_reg;
    assign s_fire   = s_tvalid & s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_RD;
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_WB;
            ST_WB:   if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg    <= s_tuser;
            id_reg      <= s_tdata[FLOW_W-1:0];
            bytes_reg   <= s_tdata[23:8];
            done_reg    <= s_tdata[24];
            inrange_reg <= (s_tdata[7:0] < 8'(FLOWS)) || (FLOWS >= 256);
        end
    end

    // ---------------- entry RAM ----------------
    entry_t rd_entry, wr_entry;
    logic   ram_we;

    pfcrc_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOWS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata (wr_entry),
        .raddr (s_tdata[FLOW_W-1:0]),
        .rdata (rd_entry)
    );

    // ---------------- stage MUL: register products ----------------
    entry_t             ent_reg;
    logic [ALPHA_W-1:0] g_eff, a_eff, omg;
    logic [RATE_W+ALPHA_W:0] cut_prod_reg;
    logic [33:0]        adec_prod_reg;
    logic [7:0]         hyp_inc_reg;
    logic [31:0]        hyp_prod_reg;
    logic               was_valid_reg;
    logic [7:0]         hyp_c;
    logic [7:0]         bs_now, ts_now, hi_s, lo_s;
    logic               is_open;

    assign g_eff   = (gamma_reg > ALPHA_ONE) ? ALPHA_ONE : gamma_reg;
    assign omg     = ALPHA_ONE - g_eff;
    assign is_open = (func_reg == FN_OPEN) & ~valid_reg[id_reg];

    entry_t base;
    always_comb begin
        base = rd_entry;
        if (is_open) begin
            base.cur    = init_rate_reg;
            base.tgt    = init_rate_reg;
            base.alpha  = ALPHA_ONE;
            base.bcnt   = '0;
            base.bsteps = '0;
            base.tsteps = '0;
            base.hyper  = '0;
            base.accel  = ACC_NORMAL;
        end
    end

    assign a_eff  = (base.alpha > ALPHA_ONE) ? ALPHA_ONE : base.alpha;
    assign hyp_c  = sat8_inc(base.hyper);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            ent_reg       <= base;
            was_valid_reg <= valid_reg[id_reg] | is_open;
            cut_prod_reg  <= base.cur * ((ALPHA_W+1)'(2*65536) - {1'b0, a_eff});
            adec_prod_reg <= omg * a_eff;
            hyp_inc_reg   <= hyp_c;
            hyp_prod_reg  <= hyp_c * rate_hai_reg;
        end
    end

    // ---------------- stage WB: finish the update ----------------
    entry_t nxt;
    logic   rrt, rat, step;
    logic [25:0] bc_sum;
    logic [BCNT_W-1:0] bc_sat;
    logic [RATE_W+3:0] tgt_w;
    logic [RATE_W:0]   cur_sum;
    logic [34:0]       ainc;
    logic [1:0]        st;
    logic              ok;

    always_comb begin
        nxt    = ent_reg;
        rrt    = 1'b0;
        rat    = 1'b0;
        step   = 1'b0;
        ok     = inrange_reg & was_valid_reg & (func_reg <= FN_SENT);
        bc_sum = {1'b0, ent_reg.bcnt} + {10'd0, bytes_reg};
        bc_sat = bc_sum[25] ? {BCNT_W{1'b1}} : bc_sum[BCNT_W-1:0];
        ainc   = {1'b0, adec_prod_reg} + {1'b0, g_eff, 16'd0};
        unique case (func_reg)
            FN_CNP: begin
                nxt.tgt    = ent_reg.cur;
                nxt.cur    = cut_prod_reg[RATE_W+17-1:17];
                nxt.alpha  = (ainc[34:16] > 19'(ALPHA_ONE)) ? ALPHA_ONE : ainc[32:16];
                nxt.bcnt   = '0;
                nxt.bsteps = '0;
                nxt.tsteps = '0;
                nxt.hyper  = '0;
                rrt = 1'b1;
                rat = 1'b1;
            end
            FN_RTMR: begin
                nxt.tsteps = sat8_inc(ent_reg.tsteps);
                step = 1'b1;
                rrt  = 1'b1;
            end
            FN_ATMR: begin
                nxt.alpha = adec_prod_reg[32:16];
                rat = 1'b1;
            end
            FN_SENT: begin
                if (!done_reg && ent_reg.accel != ACC_NORMAL) begin
                    if ({1'b0, bc_sat} >= {2'b0, byte_th_reg}) begin
                        nxt.bcnt   = '0;
                        nxt.bsteps = sat8_inc(ent_reg.bsteps);
                        step = 1'b1;
                    end else begin
                        nxt.bcnt = bc_sat;
                    end
                end
            end
            default: ;
        endcase

        bs_now = nxt.bsteps;
        ts_now = nxt.tsteps;
        hi_s   = (bs_now > ts_now) ? bs_now : ts_now;
        lo_s   = (bs_now < ts_now) ? bs_now : ts_now;
        if (hi_s < fr_th_reg)      st = ACC_FR;
        else if (lo_s > fr_th_reg) st = ACC_HYPER;
        else                       st = ACC_AI;
        tgt_w = {4'b0, ent_reg.tgt};
        if (st == ACC_AI)    tgt_w = {4'b0, ent_reg.tgt} + {9'd0, rate_ai_reg};
        if (st == ACC_HYPER) tgt_w = {4'b0, ent_reg.tgt} + {1'b0, hyp_prod_reg};
        if (st != ACC_FR && tgt_w > {4'b0, max_rate_reg}) tgt_w = {4'b0, max_rate_reg};
        cur_sum = {1'b0, ent_reg.cur} + {1'b0, tgt_w[RATE_W-1:0]};
        if (step) begin
            nxt.accel = st;
            if (st == ACC_HYPER) nxt.hyper = hyp_inc_reg;
            nxt.tgt   = tgt_w[RATE_W-1:0];
            nxt.cur   = cur_sum[RATE_W:1];
        end
        wr_entry = nxt;
        ram_we   = (state_reg == ST_WB) & out_free & ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            if (func_reg == FN_OPEN) valid_reg[id_reg] <= 1'b1;
            else if (func_reg == FN_SENT && done_reg) valid_reg[id_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_WB && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WB && out_free) begin
            m_data_reg <= {1'b0,
                           ok & rat, ok & rrt,
                           ok ? nxt.accel : 2'b0,
                           ok ? nxt.tgt : {RATE_W{1'b0}},
                           ok ? nxt.cur : {RATE_W{1'b0}},
                           ok,
                           8'(id_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

// File: src/pfcrc_checker.sv
`include "assert_macros.svh"
module pfcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    // a result without found carries no rate and no restart
    `ASSERT_IMPL(a_nofound_zero, aclk, aresetn, m_tvalid && !m_tdata[8],
                 m_tdata[70:9] == 62'd0)
    // one event at a time: no new transfer the cycle after one
    `ASSERT_NEXT(a_no_back2back, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))
    // input closed while a result waits
    `ASSERT_IMPL(a_busy, aclk, aresetn, m_tvalid, !s_tready)
endmodule

bind per_flow_congestion_rate_control_top pfcrc_checker u_pfcrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
